/* hdl/ncc_pkg.sv */
// ----------------------------------------------------------------------------
// ncc_pkg
// Shared sizes, codes and types for the negative cycle check block.
// ----------------------------------------------------------------------------
package ncc_pkg;

    // Sizes
    localparam int MAX_VERTICES = 16;
    localparam int WEIGHT_BITS  = 16;
    localparam int DIST_BITS    = 24;
    localparam int VC_W         = 5;
    localparam int VC_RESET     = 16;

    localparam int VIDX_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int ADDR_W    = 2 * VIDX_W;
    localparam int ADJ_DEPTH = 1 << ADDR_W;
    localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
    localparam int SUM_W     = ((DIST_BITS > WEIGHT_BITS) ? DIST_BITS : WEIGHT_BITS) + 1;

    // Saturation bounds of a distance, at sum width
    localparam logic signed [SUM_W-1:0] DIST_HI =
        SUM_W'((longint'(1) <<< (DIST_BITS - 1)) - longint'(1));
    localparam logic signed [SUM_W-1:0] DIST_LO = -DIST_HI - SUM_W'(1);

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_RUN   = 1'b1;

    typedef logic signed [WEIGHT_BITS-1:0] t_weight;
    typedef logic signed [DIST_BITS-1:0]   t_dist;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } t_state;

    // Operands of one edge relaxation
    typedef struct packed {
        t_weight weight;
        t_dist   du;
        logic    ru;
        t_dist   dv;
        logic    rv;
    } t_relax_req;

    // Outcome of one edge relaxation
    typedef struct packed {
        logic  relaxes;
        t_dist new_dist;
    } t_relax_rsp;

endpackage

/* hdl/negative_cycle_check.sv */
// ----------------------------------------------------------------------------
// negative_cycle_check
// Bellman-Ford negative cycle check over a written adjacency matrix.
// ----------------------------------------------------------------------------
// channel  direction  handshake                   payload
// in       input      i_in_valid / o_in_stall     i_kind, i_from_vertex,
//                                                 i_to_vertex, i_weight
// out      output     o_out_valid / i_out_stall   o_negative_cycle
// cfg      input      i_cfg_valid / o_cfg_ready   i_vertex_count
//
// A matrix write item gives no result. A run item makes n passes over
// the vertex pairs (n vertices in use): in every pass each pair costs one
// adjacency memory read and one pass through the shared relaxation unit;
// the check pass ends early on the first relaxing edge. A finished run
// waits for a stalled result to leave the output register.
// Input is stalled while a run is in progress; write items are taken while
// a result waits on a stalled output. Reset clears the matrix to no edges
// at once through valid bits and sets vertex_count to 16.
// ----------------------------------------------------------------------------
module negative_cycle_check
    import ncc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input items
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [0:0]             i_kind,
    input  logic [3:0]             i_from_vertex,
    input  logic [3:0]             i_to_vertex,
    input  logic signed [15:0]     i_weight,
    // result items
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [0:0]             o_negative_cycle,
    // configuration
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [VC_W-1:0]        i_vertex_count
);

    t_state              r_state;
    t_state              n_state;

    logic [VC_W-1:0]     r_vc;
    logic [VIDX_W-1:0]   r_u;
    logic [VIDX_W-1:0]   r_v;
    logic [VIDX_W-1:0]   r_pass;
    t_dist               r_dist [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_reach;
    t_dist               r_du;
    logic                r_ru;
    logic                r_res;
    logic                r_out_valid;
    logic                r_out_neg;

    logic                w_in_fire;
    logic                w_run_start;
    logic                w_mem_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [ADDR_W-1:0]   w_raddr;
    t_weight             w_rdata;
    t_weight             w_wdata;
    logic [CNT_W-1:0]    w_n;
    logic [VIDX_W-1:0]   w_last;
    logic                w_check;
    logic                w_v_last;
    logic                w_u_last;
    logic                w_slot_free;
    logic                w_eval;
    logic                w_publish;
    t_relax_req          w_req;
    t_relax_rsp          w_rsp;

    // Effective vertex count, clamped to 1..MAX_VERTICES
    always_comb begin
        if (r_vc == '0) begin
            w_n = CNT_W'(1);
        end else if (int'(r_vc) > MAX_VERTICES) begin
            w_n = CNT_W'(MAX_VERTICES);
        end else begin
            w_n = CNT_W'(r_vc);
        end
    end

    assign w_last   = VIDX_W'(w_n - CNT_W'(1));
    assign w_check  = (r_pass == w_last);
    assign w_v_last = (r_v == w_last);
    assign w_u_last = (r_u == w_last);

    // Handshakes
    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign w_run_start = w_in_fire && (i_kind == KIND_RUN);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Matrix write port
    assign w_mem_we = w_in_fire && (i_kind == KIND_WRITE)
                      && (int'(i_from_vertex) < MAX_VERTICES)
                      && (int'(i_to_vertex) < MAX_VERTICES);
    assign w_waddr  = {VIDX_W'(i_from_vertex), VIDX_W'(i_to_vertex)};
    assign w_wdata  = WEIGHT_BITS'(i_weight);
    assign w_raddr  = {r_u, r_v};

    ncc_adj_mem u_adj_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Relaxation operands for the current pair
    assign w_req.weight = w_rdata;
    assign w_req.du     = r_du;
    assign w_req.ru     = r_ru;
    assign w_req.dv     = r_dist[r_v];
    assign w_req.rv     = r_reach[r_v];

    ncc_relax_unit u_relax (
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_run_start) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_check && w_rsp.relaxes) begin
                    n_state = S_DONE;
                end else if (w_check && w_u_last && w_v_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_eval     = 1'b0;
        w_publish  = 1'b0;
        case (r_state)
            S_IDLE: o_in_stall = 1'b0;
            S_READ: o_in_stall = 1'b1;
            S_EVAL: w_eval     = 1'b1;
            S_DONE: w_publish  = w_slot_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vc        <= VC_W'(VC_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_vc <= i_vertex_count;
            end
            if (w_publish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sequencer counters, distances and result
    always_ff @(posedge i_clk) begin
        if (w_run_start) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
                r_dist[i] <= '0;
            end
            r_reach    <= MAX_VERTICES'(1);
            r_u        <= '0;
            r_v        <= '0;
            r_pass     <= '0;
            r_res      <= 1'b0;
        end
        // Row start: latch source distance
        if ((r_state == S_READ) && (r_v == '0)) begin
            r_du <= r_dist[r_u];
            r_ru <= r_reach[r_u];
        end
        if (w_eval) begin
            if (w_check) begin
                r_res <= w_rsp.relaxes;
            end else if (w_rsp.relaxes) begin
                r_dist[r_v]  <= w_rsp.new_dist;
                r_reach[r_v] <= 1'b1;
                if (r_v == r_u) begin
                    r_du <= w_rsp.new_dist;
                end
            end
            // Advance over pairs and passes
            if (w_v_last) begin
                r_v <= '0;
                if (w_u_last) begin
                    r_u    <= '0;
                    r_pass <= r_pass + VIDX_W'(1);
                end else begin
                    r_u <= r_u + VIDX_W'(1);
                end
            end else begin
                r_v <= r_v + VIDX_W'(1);
            end
        end
        if (w_publish) begin
            r_out_neg <= r_res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_negative_cycle = r_out_neg;

endmodule

/* hdl/ncc_adj_mem.sv */
// ----------------------------------------------------------------------------
// ncc_adj_mem
// Adjacency weight memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero (no edge).
// ----------------------------------------------------------------------------
module ncc_adj_mem
    import ncc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_weight           i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_weight           o_rdata
);

    t_weight                r_mem [ADJ_DEPTH];
    logic [ADJ_DEPTH-1:0]   r_vld;
    t_weight                r_rd_data;
    logic                   r_rd_vld;

    // Storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_data <= r_mem[i_raddr];
    end

    // Valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_data : '0;

endmodule

/* hdl/ncc_relax_unit.sv */
// ----------------------------------------------------------------------------
// ncc_relax_unit
// Shared edge relaxation unit: one add, one compare, saturation to the
// distance range.
// ----------------------------------------------------------------------------
module ncc_relax_unit
    import ncc_pkg::*;
(
    input  t_relax_req i_req,
    output t_relax_rsp o_rsp
);

    logic signed [SUM_W-1:0] w_cand;
    logic signed [SUM_W-1:0] w_dv;

    // Candidate distance at full width
    assign w_cand = SUM_W'(i_req.du) + SUM_W'(i_req.weight);
    assign w_dv   = SUM_W'(i_req.dv);

    // Relax decision and saturated new distance
    always_comb begin
        // Edge present, source reached, target unreached or improved
        o_rsp.relaxes = (i_req.weight != '0) && i_req.ru
                        && (!i_req.rv || (w_cand < w_dv));
        if (w_cand > DIST_HI) begin
            o_rsp.new_dist = DIST_HI[DIST_BITS-1:0];
        end else if (w_cand < DIST_LO) begin
            o_rsp.new_dist = DIST_LO[DIST_BITS-1:0];
        end else begin
            o_rsp.new_dist = w_cand[DIST_BITS-1:0];
        end
    end

endmodule

/* dv/ncc_checker.sv */
// ----------------------------------------------------------------------------
// ncc_checker
// Watches the item, result and register channels of the negative cycle
// check block. It keeps its own copy of the adjacency matrix and of
// vertex_count, works out the verdict of every run item and compares it
// with the result items in order.
// ----------------------------------------------------------------------------
module ncc_checker
    import ncc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item channel
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [0:0]         i_kind,
    input  logic [3:0]         i_from_vertex,
    input  logic [3:0]         i_to_vertex,
    input  logic signed [15:0] i_weight,
    // result channel
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [0:0]         i_negative_cycle,
    // register channel
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [VC_W-1:0]    i_vertex_count,
    // to the testbench top
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow state of the block
    t_weight         edge_weight [MAX_VERTICES][MAX_VERTICES];
    logic [VC_W-1:0] vertex_count_reg;

    // Verdicts of accepted runs, oldest first
    logic            awaited_verdicts [$];
    logic            awaited_flag;
    int              mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Bellman-Ford from vertex 0; the last pass only looks for an edge
    // that still relaxes and updates nothing.
    function automatic logic reachable_negative_cycle();
        t_dist  path_len [MAX_VERTICES];
        logic   reach [MAX_VERTICES];
        int     n;
        longint cand;
        longint dist_hi;
        logic   found;
        n = int'(vertex_count_reg);
        if (n < 1) n = 1;
        if (n > MAX_VERTICES) n = MAX_VERTICES;
        dist_hi = (longint'(1) <<< (DIST_BITS - 1)) - longint'(1);
        for (int i = 0; i < MAX_VERTICES; i++) begin
            path_len[i] = '0;
            reach[i]    = 1'b0;
        end
        reach[0] = 1'b1;
        found    = 1'b0;
        for (int pass = 0; pass < n; pass++) begin
            for (int u = 0; u < n; u++) begin
                for (int v = 0; v < n; v++) begin
                    if (edge_weight[u][v] != 0 && reach[u]) begin
                        cand = longint'(path_len[u]) + longint'(edge_weight[u][v]);
                        if (!reach[v] || cand < longint'(path_len[v])) begin
                            if (pass == n - 1) begin
                                found = 1'b1;
                            end else begin
                                // saturate to the distance range
                                if (cand > dist_hi) cand = dist_hi;
                                else if (cand < -dist_hi - 1) cand = -dist_hi - 1;
                                path_len[v] = t_dist'(cand);
                                reach[v]    = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        return found;
    endfunction

    // Channel monitor: results first, then items, then register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int u = 0; u < MAX_VERTICES; u++)
                for (int v = 0; v < MAX_VERTICES; v++)
                    edge_weight[u][v] = '0;
            vertex_count_reg = VC_W'(VC_RESET);
            awaited_verdicts.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (awaited_verdicts.size() == 0) begin
                    report_mismatch("result item with no run awaiting it");
                end else begin
                    awaited_flag = awaited_verdicts.pop_front();
                    if (i_negative_cycle !== awaited_flag)
                        report_mismatch($sformatf("negative_cycle %b, predicted %b",
                                                  i_negative_cycle, awaited_flag));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_kind == KIND_RUN)
                    awaited_verdicts.push_back(reachable_negative_cycle());
                else
                    edge_weight[i_from_vertex][i_to_vertex] = i_weight;
            end
            if (i_cfg_valid && i_cfg_ready)
                vertex_count_reg = i_vertex_count;
        end
        o_pending = awaited_verdicts.size();
    end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the negative cycle check block. A short directed
// part covers the vertex count extremes, self loops and unreachable cycles;
// then random phases at varied vertex counts rebuild or tweak graphs and run
// the check, with idling on both channels. The checker does the comparing.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ncc_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 2;
    localparam int RANDOM_ITEMS = 1850;
    localparam int ALL_ITEMS    = RANDOM_ITEMS + 20;
    // margin for writes to settle before a register write
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 64;
    localparam int CYCLE_LIMIT   = 2_000_000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [0:0]         i_kind = KIND_WRITE;
    logic [3:0]         i_from_vertex = '0;
    logic [3:0]         i_to_vertex = '0;
    logic signed [15:0] i_weight = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [0:0]         o_negative_cycle;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [VC_W-1:0]    i_vertex_count = VC_W'(VC_RESET);

    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    int                 items_sent = 0;
    int                 active_n = VC_RESET;
    int                 sender_idle_pct = 37;
    int                 receiver_idle_pct = 62;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    negative_cycle_check dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_from_vertex    (i_from_vertex),
        .i_to_vertex      (i_to_vertex),
        .i_weight         (i_weight),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_negative_cycle (o_negative_cycle),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_vertex_count   (i_vertex_count)
    );

    ncc_checker cycle_verdict_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_from_vertex    (i_from_vertex),
        .i_to_vertex      (i_to_vertex),
        .i_weight         (i_weight),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_negative_cycle (o_negative_cycle),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_vertex_count   (i_vertex_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge i_clk)
        i_out_stall = ($urandom_range(0, 99) < receiver_idle_pct);

    // Weight mix: mostly small, some negative, some extremes
    function automatic logic signed [15:0] rand_weight();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'($urandom_range(1, 40));
            5, 6:          return -16'($urandom_range(1, 40));
            7:             return '0;
            8:             return 16'($urandom);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
        endcase
    endfunction

    // One item on the input channel; entered and left at a falling edge
    task automatic send_item(input logic [0:0] kind, input logic [3:0] from_v,
                             input logic [3:0] to_v, input logic signed [15:0] w);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_kind        = kind;
        i_from_vertex = from_v;
        i_to_vertex   = to_v;
        i_weight      = w;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
        items_sent++;
        // idle pattern follows progress through the run
        if (items_sent >= (2 * ALL_ITEMS) / 3) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
        end else if (items_sent >= ALL_ITEMS / 3) begin
            sender_idle_pct = 62;
            receiver_idle_pct = 37;
        end
    endtask

    task automatic send_run();
        send_item(KIND_RUN, 4'($urandom), 4'($urandom), 16'($urandom));
    endtask

    // Hold the input until every verdict is back, then let writes settle
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [VC_W-1:0] value);
        wait_drained();
        i_cfg_valid    = 1'b1;
        i_vertex_count = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (value == 0) active_n = 1;
        else if (value > MAX_VERTICES) active_n = MAX_VERTICES;
        else active_n = int'(value);
    endtask

    initial begin
        int              seq_kind;
        int              phase_runs;
        logic [VC_W-1:0] vc;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty graph at reset size, self loop at vertex 0
        send_run();
        send_item(KIND_WRITE, 4'd0, 4'd0, -16'sd1);
        send_run();
        // one vertex, and zero taken as one
        write_vertex_count(VC_W'(1));
        send_run();
        write_vertex_count('0);
        send_run();
        send_item(KIND_WRITE, 4'd0, 4'd0, 16'sh7FFF);
        send_run();
        // oversize count saturates; cycle through the highest vertex
        write_vertex_count('1);
        send_item(KIND_WRITE, 4'd0, 4'd15, 16'sh8000);
        send_item(KIND_WRITE, 4'd15, 4'd0, 16'sh7FFF);
        send_run();
        send_item(KIND_WRITE, 4'd0, 4'd0, 16'sd0);
        // cycle not reachable from vertex 0, then made reachable
        write_vertex_count(VC_W'(4));
        send_item(KIND_WRITE, 4'd2, 4'd3, -16'sd5);
        send_item(KIND_WRITE, 4'd3, 4'd2, -16'sd5);
        send_run();
        send_item(KIND_WRITE, 4'd0, 4'd2, 16'sd7);
        send_run();
        send_item(KIND_WRITE, 4'd3, 4'd2, 16'sd10);
        send_run();
        // entry beyond the vertex count is kept but ignored
        send_item(KIND_WRITE, 4'd15, 4'd15, -16'sd1);
        send_run();

        // Random phases, each at its own vertex count
        while (items_sent < ALL_ITEMS) begin
            case ($urandom_range(0, 19))
                0:       vc = VC_W'(16);
                1:       vc = '1;
                2:       vc = '0;
                3:       vc = VC_W'($urandom_range(7, 15));
                4:       vc = VC_W'($urandom_range(17, 30));
                default: vc = VC_W'($urandom_range(1, 6));
            endcase
            write_vertex_count(vc);
            // big graphs are slow to run: keep their phases short
            phase_runs = (active_n >= 8) ? 2 : 12;
            repeat (phase_runs) begin
                if ($urandom_range(0, 7) == 0) wait_drained();
                seq_kind = $urandom_range(0, 19);
                if (seq_kind < 5) begin
                    // rebuild the whole graph in use, then run
                    for (int u = 0; u < active_n; u++)
                        for (int v = 0; v < active_n; v++)
                            send_item(KIND_WRITE, 4'(u), 4'(v),
                                      ($urandom_range(0, 99) < 55) ? 16'sd0
                                                                  : rand_weight());
                    send_run();
                end else if (seq_kind < 15) begin
                    // tweak a few edges, then run
                    repeat ($urandom_range(1, 4))
                        send_item(KIND_WRITE, 4'($urandom_range(0, active_n - 1)),
                                  4'($urandom_range(0, active_n - 1)), rand_weight());
                    send_run();
                end else if (seq_kind < 18) begin
                    // noise: any fields, any kind
                    repeat ($urandom_range(1, 6))
                        send_item(($urandom_range(0, 3) == 0) ? KIND_RUN : KIND_WRITE,
                                  4'($urandom), 4'($urandom), 16'($urandom));
                end else begin
                    // broken sequence: edges with no run after them
                    repeat ($urandom_range(1, 3))
                        send_item(KIND_WRITE, 4'($urandom_range(0, active_n - 1)),
                                  4'($urandom_range(0, active_n - 1)), rand_weight());
                end
            end
        end

        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
